FILE: hw/rtl/itp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix-to-postfix converter
// Operator codes, precedence and character tables, the command that travels
// from the front end to the back end, and status codes of the result stream.
// ----------------------------------------------------------------------------
package itp_pkg;

    // Default operator stack depth
    localparam int STACK_DEPTH = 16;

    // Command queue between front end and back end
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // ASCII characters that steer the conversion
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2a;
    localparam logic [7:0] CH_ADD    = 8'h2b;
    localparam logic [7:0] CH_SUB    = 8'h2d;
    localparam logic [7:0] CH_DIV    = 8'h2f;
    localparam logic [7:0] CH_POW    = 8'h5e;
    localparam logic [7:0] CH_NONE   = 8'h00;

    // Stack entry codes
    localparam int CODE_W = 3;
    localparam logic [CODE_W-1:0] CODE_OPEN = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ADD  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SUB  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_MUL  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DIV  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_POW  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK              = 2'd0;
    localparam logic [1:0] ST_UNMATCHED_CLOSE = 2'd1;
    localparam logic [1:0] ST_UNMATCHED_OPEN  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW        = 2'd3;

    typedef enum logic [1:0] {
        K_OTHER,
        K_OPEN,
        K_CLOSE,
        K_OPER
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CODE_W-1:0] code;
        logic [7:0]        ch;
        logic              last;
    } t_cmd;

    // Precedence of a stack entry; open parenthesis ranks lowest
    function automatic logic [1:0] code_prec(input logic [CODE_W-1:0] code);
        logic [1:0] prec;
        case (code)
            CODE_ADD, CODE_SUB: prec = 2'd1;
            CODE_MUL, CODE_DIV: prec = 2'd2;
            CODE_POW:           prec = 2'd3;
            default:            prec = 2'd0;
        endcase
        return prec;
    endfunction

    // Character that a popped stack entry emits
    function automatic logic [7:0] code_char(input logic [CODE_W-1:0] code);
        logic [7:0] ch;
        case (code)
            CODE_OPEN: ch = CH_LPAREN;
            CODE_ADD:  ch = CH_ADD;
            CODE_SUB:  ch = CH_SUB;
            CODE_MUL:  ch = CH_MUL;
            CODE_DIV:  ch = CH_DIV;
            CODE_POW:  ch = CH_POW;
            default:   ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/itp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_if: channel interfaces of the infix-to-postfix converter
// Input channel carries one infix character per transaction, output channel
// one postfix character or status per transaction; valid/ready handshake.
// ----------------------------------------------------------------------------
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_last;

    modport source (output valid, output in_char, output is_last, input ready);
    modport sink   (input valid, input in_char, input is_last, output ready);
endinterface

interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_char, output out_last, output status,
                    input ready);
    modport sink   (input valid, input out_char, input out_last, input status,
                    output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/itp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/itp_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_cmd_queue: short command queue between front end and back end
// Holds classified commands so that each side can stall on its own.
// ----------------------------------------------------------------------------
module itp_cmd_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire itp_pkg::t_cmd i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output itp_pkg::t_cmd     o_cmd,
    input  wire logic         i_pop
);

    localparam int AW = itp_pkg::QUEUE_AW;
    localparam int CW = AW + 1;

    itp_pkg::t_cmd   r_entry [itp_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(itp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_entry[r_rptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/itp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_front: input acceptance and character classification
// Accepts infix characters and turns each into a command for the back end.
// ----------------------------------------------------------------------------
module itp_front (
    itp_in_if.sink            i_in,
    input  wire logic         i_full,
    output logic              o_push,
    output itp_pkg::t_cmd     o_cmd
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Classify the character
    always_comb begin
        o_cmd.ch   = i_in.in_char;
        o_cmd.last = i_in.is_last;
        o_cmd.code = itp_pkg::CODE_OPEN;
        case (i_in.in_char)
            itp_pkg::CH_LPAREN: begin
                o_cmd.kind = itp_pkg::K_OPEN;
            end
            itp_pkg::CH_RPAREN: begin
                o_cmd.kind = itp_pkg::K_CLOSE;
            end
            itp_pkg::CH_ADD: begin
                o_cmd.kind = itp_pkg::K_OPER;
                o_cmd.code = itp_pkg::CODE_ADD;
            end
            itp_pkg::CH_SUB: begin
                o_cmd.kind = itp_pkg::K_OPER;
                o_cmd.code = itp_pkg::CODE_SUB;
            end
            itp_pkg::CH_MUL: begin
                o_cmd.kind = itp_pkg::K_OPER;
                o_cmd.code = itp_pkg::CODE_MUL;
            end
            itp_pkg::CH_DIV: begin
                o_cmd.kind = itp_pkg::K_OPER;
                o_cmd.code = itp_pkg::CODE_DIV;
            end
            itp_pkg::CH_POW: begin
                o_cmd.kind = itp_pkg::K_OPER;
                o_cmd.code = itp_pkg::CODE_POW;
            end
            default: begin
                o_cmd.kind = itp_pkg::K_OTHER;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/itp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_back: operator stack engine
// Executes commands against the operator stack (RAM plus cached top entry)
// and feeds the output register through a one-result holding stage, so the
// final result of each item can be marked before it leaves.
// ----------------------------------------------------------------------------
module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire itp_pkg::t_cmd i_cmd,
    output logic               o_pop,
    itp_out_if.source          o_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int CODE_W = itp_pkg::CODE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_POST,
        S_FLUSH,
        S_END
    } t_state;

    t_state              r_state, n_state;
    t_state              r_ret, n_ret;
    itp_pkg::t_cmd       r_cmd, n_cmd;
    logic [CW-1:0]       r_count, n_count;
    logic [CODE_W-1:0]   r_top, n_top;
    logic                r_open_seen, n_open_seen;
    logic                r_pend_valid, n_pend_valid;
    logic [7:0]          r_pend_char, n_pend_char;
    logic [1:0]          r_pend_status, n_pend_status;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_char, n_out_char;
    logic                r_out_last, n_out_last;
    logic [1:0]          r_out_status, n_out_status;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CODE_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [CODE_W-1:0]   ram_rdata;

    logic                out_ok;
    logic                emit_ok;
    logic                emit_req;
    logic [7:0]          emit_char;
    logic [1:0]          emit_status;
    logic                pop_req;
    t_state              pop_ret;
    logic                full;
    logic                top_pops;

    itp_ram #(
        .WIDTH (CODE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.out_last = r_out_last;
    assign o_out.status   = r_out_status;

    assign out_ok   = !r_out_valid || o_out.ready;
    assign emit_ok  = !r_pend_valid || out_ok;
    assign full     = (r_count == CW'(STACK_DEPTH));
    // Stacked operator that an incoming operator pops first
    assign top_pops = (r_count != '0) && (r_top != itp_pkg::CODE_OPEN) &&
                      (itp_pkg::code_prec(r_top) >= itp_pkg::code_prec(r_cmd.code));

    // Next-state logic
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_cmd         = r_cmd;
        n_count       = r_count;
        n_top         = r_top;
        n_open_seen   = r_open_seen;
        n_pend_valid  = r_pend_valid;
        n_pend_char   = r_pend_char;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_char    = r_out_char;
        n_out_last    = r_out_last;
        n_out_status  = r_out_status;
        o_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_count[AW-1:0];
        ram_wdata     = r_cmd.code;
        ram_raddr     = AW'(r_count - CW'(2));
        emit_req      = 1'b0;
        emit_char     = itp_pkg::CH_NONE;
        emit_status   = itp_pkg::ST_OK;
        pop_req       = 1'b0;
        pop_ret       = S_EXEC;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop       = 1'b1;
                    n_cmd       = i_cmd;
                    n_open_seen = 1'b0;
                    n_state     = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_cmd.kind)
                    itp_pkg::K_OTHER: begin
                        if (emit_ok) begin
                            emit_req  = 1'b1;
                            emit_char = r_cmd.ch;
                            n_state   = S_POST;
                        end
                    end
                    itp_pkg::K_OPEN, itp_pkg::K_OPER: begin
                        if ((r_cmd.kind == itp_pkg::K_OPER) && top_pops) begin
                            // Pop an operator of greater or equal precedence
                            if (emit_ok) begin
                                emit_req  = 1'b1;
                                emit_char = itp_pkg::code_char(r_top);
                                pop_req   = 1'b1;
                                pop_ret   = S_EXEC;
                            end
                        end else if (full) begin
                            // Drop the push and flag overflow
                            if (emit_ok) begin
                                emit_req    = 1'b1;
                                emit_status = itp_pkg::ST_OVERFLOW;
                                n_state     = S_POST;
                            end
                        end else begin
                            ram_we  = 1'b1;
                            n_top   = r_cmd.code;
                            n_count = r_count + CW'(1);
                            n_state = S_POST;
                        end
                    end
                    itp_pkg::K_CLOSE: begin
                        if (r_count == '0) begin
                            if (emit_ok) begin
                                emit_req    = 1'b1;
                                emit_status = itp_pkg::ST_UNMATCHED_CLOSE;
                                n_state     = S_POST;
                            end
                        end else if (r_top == itp_pkg::CODE_OPEN) begin
                            // Discard the matching open parenthesis
                            pop_req = 1'b1;
                            pop_ret = S_POST;
                        end else if (emit_ok) begin
                            emit_req  = 1'b1;
                            emit_char = itp_pkg::code_char(r_top);
                            pop_req   = 1'b1;
                            pop_ret   = S_EXEC;
                        end
                    end
                endcase
            end

            S_LOAD: begin
                n_top   = ram_rdata;
                n_state = r_ret;
            end

            S_POST: begin
                n_state = r_cmd.last ? S_FLUSH : S_END;
            end

            S_FLUSH: begin
                if (r_count != '0) begin
                    if (r_top == itp_pkg::CODE_OPEN) begin
                        n_open_seen = 1'b1;
                        pop_req     = 1'b1;
                        pop_ret     = S_FLUSH;
                    end else if (emit_ok) begin
                        emit_req  = 1'b1;
                        emit_char = itp_pkg::code_char(r_top);
                        pop_req   = 1'b1;
                        pop_ret   = S_FLUSH;
                    end
                end else if (r_open_seen || !r_pend_valid) begin
                    // Closing status so that the final result always exists
                    if (emit_ok) begin
                        emit_req    = 1'b1;
                        emit_status = r_open_seen ? itp_pkg::ST_UNMATCHED_OPEN
                                                  : itp_pkg::ST_OK;
                        n_state     = S_END;
                    end
                end else begin
                    n_state = S_END;
                end
            end

            S_END: begin
                // Drain the held result, marked if it ends the expression
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_ok) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = r_pend_char;
                    n_out_status = r_pend_status;
                    n_out_last   = r_cmd.last;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Shift a new result through the holding stage
        if (emit_req) begin
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out_char   = r_pend_char;
                n_out_status = r_pend_status;
                n_out_last   = 1'b0;
            end
            n_pend_valid  = 1'b1;
            n_pend_char   = emit_char;
            n_pend_status = emit_status;
        end

        // Pop the top entry and fetch the one below it
        if (pop_req) begin
            n_count = r_count - CW'(1);
            if (r_count > CW'(1)) begin
                n_state = S_LOAD;
                n_ret   = pop_ret;
            end else begin
                n_state = pop_ret;
            end
        end
    end

    // Hold state, stack pointer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_EXEC;
            r_count      <= '0;
            r_open_seen  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_count      <= n_count;
            r_open_seen  <= n_open_seen;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_cmd         <= n_cmd;
        r_top         <= n_top;
        r_pend_char   <= n_pend_char;
        r_pend_status <= n_pend_status;
        r_out_char    <= n_out_char;
        r_out_last    <= n_out_last;
        r_out_status  <= n_out_status;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/infix_to_postfix_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// Takes one infix character per input transaction and produces postfix
// characters and status results on the output channel.
//
// Input channel i_in: in_char and is_last; is_last closes the expression and
// flushes the operator stack. Output channel o_out: out_char, out_last (set
// on the final result of the final character) and status (ok, unmatched
// close, unmatched open at end, stack overflow; out_char is 0 on a status).
// A front end classifies characters into a two-entry command queue; the
// back end runs the operator stack, kept in a RAM with the top entry cached.
// In the back end, each operator that an item pops takes a pop step and
// a stack RAM read of the new top, and a flush pops each stacked entry
// in the same manner. Each result passes a holding register and an
// output register, so when the receiver stalls the back end halts while
// the front end keeps taking characters until the queue is full. Reset
// empties the queue and the stack; the block then takes a character at
// once.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itp_in_if.sink     i_in,
    itp_out_if.source  o_out
);

    logic          q_push;
    logic          q_full;
    itp_pkg::t_cmd q_wcmd;
    logic          q_valid;
    itp_pkg::t_cmd q_rcmd;
    logic          q_pop;

    itp_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (q_push),
        .o_cmd  (q_wcmd)
    );

    itp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wcmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_rcmd),
        .i_pop   (q_pop)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_rcmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
